### src/sigma_clipped_batch_mean_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared assertion forms for the sigma-clipped batch mean unit.
// ----------------------------------------------------------------------------
`ifndef SIGMA_CLIPPED_BATCH_MEAN_UNIT_MACROS_SVH
`define SIGMA_CLIPPED_BATCH_MEAN_UNIT_MACROS_SVH

// Checked on every clock edge outside reset.
`define SCBM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define SCBM_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/scbm_pkg.sv
// ----------------------------------------------------------------------------
// scbm_pkg
// Types and constants shared by the sigma-clipped batch mean unit.
// ----------------------------------------------------------------------------
package scbm_pkg;

  localparam int SAMPLE_W        = 24;
  localparam int CFG_W           = 8;
  localparam int DEV_W           = 23;
  localparam int KEPT_W          = 8;
  localparam int MAX_BATCH_DEF   = 128;
  localparam int MIN_BATCH       = 4;
  localparam int N_MAX_W         = 11;
  localparam logic [CFG_W-1:0] BATCH_SIZE_RESET = 8'd10;
  localparam logic [SAMPLE_W-1:0] Q_MAX = 24'h7FFFFF;

  typedef struct packed {
    logic [N_MAX_W-1:0] n;
  } job_t;

  typedef struct packed {
    logic busy;
    logic done;
  } back_stat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SUM,
    ST_MDIV,
    ST_SQ,
    ST_VDIV,
    ST_SQRT,
    ST_BAND,
    ST_CLIP,
    ST_KDIV,
    ST_DONE
  } back_state_t;

endpackage

### src/scbm_ram.sv
// ----------------------------------------------------------------------------
// scbm_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module scbm_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

### src/scbm_jobq.sv
// ----------------------------------------------------------------------------
// scbm_jobq
// Two-entry queue of completed batches between the front and back parts.
// ----------------------------------------------------------------------------
module scbm_jobq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  scbm_pkg::job_t wr_job,
  input  logic          rd_en,
  output scbm_pkg::job_t rd_job,
  output logic          valid,
  output logic          qfull
);
  import scbm_pkg::*;

  job_t       slot_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_wr, do_rd;

  assign valid  = (cnt_r != 2'd0);
  assign qfull  = (cnt_r == 2'd2);
  assign rd_job = slot_r[rp_r];
  assign do_wr  = wr_en && !qfull;
  assign do_rd  = rd_en && valid;

  always_comb begin
    wp_nxt  = do_wr ? !wp_r : wp_r;
    rp_nxt  = do_rd ? !rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(do_wr) - 2'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wp_r] <= wr_job;
    end
  end
endmodule

### src/scbm_front.sv
// ----------------------------------------------------------------------------
// scbm_front
// Accepts samples, writes them to the store and queues each completed batch.
// ----------------------------------------------------------------------------
module scbm_front #(
  parameter int MAX_BATCH = scbm_pkg::MAX_BATCH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [scbm_pkg::CFG_W-1:0]        cfg_wr_data,
  input  logic                              push,
  input  logic signed [scbm_pkg::SAMPLE_W-1:0] in_offset_sample,
  output logic                              full,
  input  logic                              jq_valid,
  input  logic                              jq_full,
  input  scbm_pkg::back_stat_t              bstat,
  output logic                              ram_we,
  output logic [$clog2(MAX_BATCH)-1:0]      ram_waddr,
  output logic [scbm_pkg::SAMPLE_W-1:0]     ram_wdata,
  output logic                              job_push,
  output scbm_pkg::job_t                    job
);
  import scbm_pkg::*;

  localparam int AW = $clog2(MAX_BATCH);
  localparam int NW = $clog2(MAX_BATCH + 1);

  logic [CFG_W-1:0]   bs_r, bs_nxt;
  logic [NW-1:0]      fill_r, fill_nxt, fill_inc, n_eff;
  logic [N_MAX_W-1:0] bs_wide;
  logic               accept;

  assign bs_wide = N_MAX_W'(bs_r);
  assign full    = jq_valid || jq_full || bstat.busy;
  assign accept  = push && !full;

  always_comb begin
    if (bs_wide < N_MAX_W'(MIN_BATCH)) begin
      n_eff = NW'(MIN_BATCH);
    end else if (bs_wide > N_MAX_W'(MAX_BATCH)) begin
      n_eff = NW'(MAX_BATCH);
    end else begin
      n_eff = NW'(bs_wide);
    end
  end

  always_comb begin
    fill_inc  = fill_r + NW'(1);
    bs_nxt    = cfg_wr_en ? cfg_wr_data : bs_r;
    fill_nxt  = fill_r;
    job_push  = 1'b0;
    if (accept) begin
      if (fill_inc >= n_eff) begin
        fill_nxt = '0;
        job_push = 1'b1;
      end else begin
        fill_nxt = fill_inc;
      end
    end
  end

  assign job.n     = N_MAX_W'(n_eff);
  assign ram_we    = accept;
  assign ram_waddr = fill_r[AW-1:0];
  assign ram_wdata = in_offset_sample;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bs_r   <= BATCH_SIZE_RESET;
      fill_r <= '0;
    end else begin
      bs_r   <= bs_nxt;
      fill_r <= fill_nxt;
    end
  end
endmodule

### src/scbm_back.sv
// ----------------------------------------------------------------------------
// scbm_back
// Runs the three passes over a batch, with a shared bit-serial divider and
// a digit-by-digit square root, and holds the result item.
// ----------------------------------------------------------------------------
module scbm_back #(
  parameter int MAX_BATCH = scbm_pkg::MAX_BATCH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 jq_valid,
  input  scbm_pkg::job_t                       jq_job,
  output logic                                 jq_pop,
  output logic [$clog2(MAX_BATCH)-1:0]         ram_raddr,
  input  logic [scbm_pkg::SAMPLE_W-1:0]        ram_rdata,
  output scbm_pkg::back_stat_t                 bstat,
  input  logic                                 pop,
  output logic                                 empty,
  output logic signed [scbm_pkg::SAMPLE_W-1:0] out_correction,
  output logic signed [scbm_pkg::SAMPLE_W-1:0] out_batch_mean,
  output logic [scbm_pkg::DEV_W-1:0]           out_batch_deviation,
  output logic [scbm_pkg::KEPT_W-1:0]          out_kept_count,
  output logic                                 out_status
);
  import scbm_pkg::*;

  localparam int AW  = $clog2(MAX_BATCH);
  localparam int NW  = $clog2(MAX_BATCH + 1);
  localparam int SW  = SAMPLE_W + AW + 1;
  localparam int SSW = 2 * SAMPLE_W + AW;
  localparam int DW  = SSW;
  localparam int DCW = $clog2(DW + 1);
  localparam int QW  = (SSW + 1) / 2;
  localparam int RW  = QW + 2;
  localparam int LW  = QW + 2;

  back_state_t state_r, state_nxt;

  logic [NW-1:0]              n_r, cnt_r, kcnt_r, den_r, rem_r;
  logic                       v1_r, v2_r, v3_r, neg_r, res_valid_r;
  logic signed [SW-1:0]       sum_r;
  logic signed [SAMPLE_W-1:0] mean_r, corr_r, x;
  logic signed [SAMPLE_W:0]   diff_r;
  logic [SAMPLE_W-1:0]        mag;
  logic [2*SAMPLE_W-1:0]      prod_r;
  logic [SSW-1:0]             ss_r;
  logic [DW-1:0]              num_r, num_nxt;
  logic [NW:0]                rem_sh;
  logic                       q_ge;
  logic [NW-1:0]              rem_nxt;
  logic [DCW-1:0]             step_r;
  logic [QW-1:0]              root_r, root_nxt, dev_r;
  logic [RW-1:0]              srem_r, srem_sh, srem_nxt, trial;
  logic [2*QW-1:0]            sqv_r;
  logic signed [LW-1:0]       lo_r, hi_r, xl;
  logic [SW-1:0]              abs_sum;
  logic [SAMPLE_W-1:0]        q24;
  logic                       issue, pass_end, div_last, sqrt_last;
  logic                       status_r;

  assign x       = ram_rdata;
  assign xl      = LW'(x);
  assign issue   = (cnt_r < n_r);
  assign abs_sum = sum_r[SW-1] ? SW'(-sum_r) : SW'(sum_r);
  assign q24     = num_nxt[SAMPLE_W-1:0];
  assign mag     = diff_r[SAMPLE_W] ? SAMPLE_W'(-diff_r) : SAMPLE_W'(diff_r);

  // Restoring division, one quotient bit a cycle.
  always_comb begin
    rem_sh  = {rem_r, num_r[DW-1]};
    q_ge    = (rem_sh >= {1'b0, den_r});
    rem_nxt = q_ge ? NW'(rem_sh - {1'b0, den_r}) : NW'(rem_sh);
    num_nxt = {num_r[DW-2:0], q_ge};
  end

  // Digit-by-digit square root, one result bit a cycle.
  always_comb begin
    srem_sh  = {srem_r[RW-3:0], sqv_r[2*QW-1 -: 2]};
    trial    = {root_r, 2'b01};
    srem_nxt = (srem_sh >= trial) ? (srem_sh - trial) : srem_sh;
    root_nxt = (srem_sh >= trial) ? {root_r[QW-2:0], 1'b1} : {root_r[QW-2:0], 1'b0};
  end

  assign div_last  = (step_r == DCW'(DW - 1));
  assign sqrt_last = (step_r == DCW'(QW - 1));

  always_comb begin
    unique case (state_r)
      ST_SQ:   pass_end = !issue && !v1_r && !v2_r && !v3_r;
      default: pass_end = !issue && !v1_r;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (jq_valid) state_nxt = ST_SUM;
      ST_SUM:  if (pass_end) state_nxt = ST_MDIV;
      ST_MDIV: if (div_last) state_nxt = ST_SQ;
      ST_SQ:   if (pass_end) state_nxt = ST_VDIV;
      ST_VDIV: if (div_last) state_nxt = ST_SQRT;
      ST_SQRT: if (sqrt_last) state_nxt = ST_BAND;
      ST_BAND: state_nxt = ST_CLIP;
      ST_CLIP: begin
        if (pass_end) state_nxt = (kcnt_r == '0) ? ST_DONE : ST_KDIV;
      end
      ST_KDIV: if (div_last) state_nxt = ST_DONE;
      ST_DONE: if (!res_valid_r) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    jq_pop     = (state_r == ST_IDLE) && jq_valid;
    ram_raddr  = cnt_r[AW-1:0];
    bstat.busy = (state_r != ST_IDLE);
    bstat.done = (state_r == ST_DONE) && !res_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      res_valid_r <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
    end else begin
      state_r <= state_nxt;
      v1_r    <= 1'b0;
      v2_r    <= v1_r && (state_r == ST_SQ);
      v3_r    <= v2_r;
      if ((state_r == ST_SUM || state_r == ST_SQ || state_r == ST_CLIP) && issue) begin
        v1_r <= 1'b1;
      end
      if (bstat.done) begin
        res_valid_r <= 1'b1;
      end else if (pop && res_valid_r) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_r + DCW'(1);
    unique case (state_r)
      ST_IDLE: begin
        n_r   <= NW'(jq_job.n);
        cnt_r <= '0;
        sum_r <= '0;
      end
      ST_SUM: begin
        if (issue) cnt_r <= cnt_r + NW'(1);
        if (v1_r) sum_r <= sum_r + SW'(x);
        if (pass_end) begin
          num_r  <= DW'(abs_sum + SW'(n_r >> 1));
          den_r  <= n_r;
          neg_r  <= sum_r[SW-1];
          rem_r  <= '0;
          step_r <= '0;
        end
      end
      ST_MDIV: begin
        num_r <= num_nxt;
        rem_r <= rem_nxt;
        if (div_last) begin
          mean_r <= neg_r ? SAMPLE_W'(-q24) : q24;
          cnt_r  <= '0;
          ss_r   <= '0;
        end
      end
      ST_SQ: begin
        if (issue) cnt_r <= cnt_r + NW'(1);
        if (v1_r) diff_r <= (SAMPLE_W+1)'(x) - (SAMPLE_W+1)'(mean_r);
        if (v2_r) prod_r <= mag * mag;
        if (v3_r) ss_r <= ss_r + SSW'(prod_r);
        if (pass_end) begin
          num_r  <= ss_r;
          den_r  <= n_r - NW'(1);
          rem_r  <= '0;
          step_r <= '0;
        end
      end
      ST_VDIV: begin
        num_r <= num_nxt;
        rem_r <= rem_nxt;
        if (div_last) begin
          sqv_r  <= (2*QW)'(num_nxt);
          root_r <= '0;
          srem_r <= '0;
          step_r <= '0;
        end
      end
      ST_SQRT: begin
        sqv_r  <= {sqv_r[2*QW-3:0], 2'b00};
        srem_r <= srem_nxt;
        root_r <= root_nxt;
        if (sqrt_last) dev_r <= root_nxt;
      end
      ST_BAND: begin
        lo_r   <= LW'(mean_r) - LW'(dev_r);
        hi_r   <= LW'(mean_r) + LW'(dev_r);
        cnt_r  <= '0;
        sum_r  <= '0;
        kcnt_r <= '0;
      end
      ST_CLIP: begin
        if (issue) cnt_r <= cnt_r + NW'(1);
        if (v1_r && xl > lo_r && xl < hi_r) begin
          sum_r  <= sum_r + SW'(x);
          kcnt_r <= kcnt_r + NW'(1);
        end
        if (pass_end) begin
          num_r    <= DW'(abs_sum + SW'(kcnt_r >> 1));
          den_r    <= kcnt_r;
          neg_r    <= sum_r[SW-1];
          rem_r    <= '0;
          step_r   <= '0;
          corr_r   <= '0;
          status_r <= (kcnt_r == '0);
        end
      end
      ST_KDIV: begin
        num_r <= num_nxt;
        rem_r <= rem_nxt;
        if (div_last) begin
          if (neg_r) begin
            corr_r <= (num_nxt[SAMPLE_W-1:0] > Q_MAX || num_nxt[SAMPLE_W]) ? Q_MAX : q24;
          end else begin
            corr_r <= SAMPLE_W'(-q24);
          end
        end
      end
      ST_DONE: begin
        if (!res_valid_r) begin
          out_correction      <= corr_r;
          out_batch_mean      <= mean_r;
          out_batch_deviation <= (32'(dev_r) > 32'(Q_MAX)) ? DEV_W'(Q_MAX) : DEV_W'(dev_r);
          out_kept_count      <= (32'(kcnt_r) > 32'd255) ? 8'hFF : KEPT_W'(kcnt_r);
          out_status          <= status_r;
        end
      end
      default: begin
        n_r <= n_r;
      end
    endcase
  end

  assign empty = !res_valid_r;
endmodule

### src/sigma_clipped_batch_mean_unit.sv
// ----------------------------------------------------------------------------
// sigma_clipped_batch_mean_unit
// Sigma-clipped mean of timing offsets, one result item per batch.
// ----------------------------------------------------------------------------
// Samples (signed Q8.16) enter through push/full and are stored until the
// batch holds cfg batch_size items, clamped to 4..MAX_BATCH. The batch then
// goes to the back part, which produces one result item on the out_ ports:
// correction, mean, deviation, kept count and status, read through
// empty/pop.
// A sample is taken in any cycle in which push is high and full is low.
// A batch is completed by three read passes over the store port, the
// bit-serial divider and the square root, with one division fewer when no
// sample is kept; full stays high while the back part works on it.
// If the result item is not popped, the back part waits with the next
// result and full stays high until the result register frees.
// Reset clears the fill index, loads batch_size with 10 and empties the
// result register; the sample store is not cleared.
// ----------------------------------------------------------------------------
`include "sigma_clipped_batch_mean_unit_macros.svh"

module sigma_clipped_batch_mean_unit #(
  parameter int MAX_BATCH = scbm_pkg::MAX_BATCH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [scbm_pkg::CFG_W-1:0]           cfg_wr_data,
  input  logic                                 push,
  output logic                                 full,
  input  logic signed [scbm_pkg::SAMPLE_W-1:0] in_offset_sample,
  output logic                                 empty,
  input  logic                                 pop,
  output logic signed [scbm_pkg::SAMPLE_W-1:0] out_correction,
  output logic signed [scbm_pkg::SAMPLE_W-1:0] out_batch_mean,
  output logic [scbm_pkg::DEV_W-1:0]           out_batch_deviation,
  output logic [scbm_pkg::KEPT_W-1:0]          out_kept_count,
  output logic                                 out_status
);
  import scbm_pkg::*;

  localparam int AW = $clog2(MAX_BATCH);

  logic                ram_we, job_push, jq_valid, jq_full, jq_pop;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [SAMPLE_W-1:0] ram_wdata, ram_rdata;
  job_t                job, jq_job;
  back_stat_t          bstat;

  scbm_front #(.MAX_BATCH(MAX_BATCH)) u_front (
    .clk, .rst_n, .cfg_wr_en, .cfg_wr_data, .push, .in_offset_sample, .full,
    .jq_valid, .jq_full, .bstat, .ram_we, .ram_waddr, .ram_wdata, .job_push, .job
  );

  scbm_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_BATCH)) u_store (
    .clk, .wr_en(ram_we), .wr_addr(ram_waddr), .wr_data(ram_wdata),
    .rd_addr(ram_raddr), .rd_data(ram_rdata)
  );

  scbm_jobq u_jobq (
    .clk, .rst_n, .wr_en(job_push), .wr_job(job), .rd_en(jq_pop), .rd_job(jq_job),
    .valid(jq_valid), .qfull(jq_full)
  );

  scbm_back #(.MAX_BATCH(MAX_BATCH)) u_back (
    .clk, .rst_n, .jq_valid, .jq_job, .jq_pop, .ram_raddr, .ram_rdata, .bstat,
    .pop, .empty, .out_correction, .out_batch_mean, .out_batch_deviation,
    .out_kept_count, .out_status
  );

  `SCBM_ASSERT(a_full_while_pending, jq_valid |-> full, "Item accepted over a queued batch.")
  `SCBM_ASSERT(a_status_kept, !empty |-> (out_status == (out_kept_count == 8'd0)), "Bad status.")
  `SCBM_ASSERT(a_out_from_back, $rose(!empty) |-> $past(bstat.done), "Result item without a batch.")
  `SCBM_ASSERT_RST(a_reset_empty, !rst_n |=> empty, "Result present after reset.")
endmodule

### test/sigma_clipped_batch_mean_unit_tb.sv
// ----------------------------------------------------------------------------
// sigma_clipped_batch_mean_unit_tb
// Self-checking testbench for the sigma-clipped batch mean unit.
// ----------------------------------------------------------------------------
// Offset samples are pushed through the input queue interface while the
// testbench keeps its own copy of the sample store and fill index. Each
// completed batch is predicted with exact integer arithmetic and compared,
// field by field, with the result item popped from the unit. Several batch
// sizes are used, including out-of-range values that the unit clamps, and
// both sides idle at random.
// ----------------------------------------------------------------------------
module sigma_clipped_batch_mean_unit_tb;
  import scbm_pkg::*;

  typedef struct {
    logic signed [SAMPLE_W-1:0] correction;
    logic signed [SAMPLE_W-1:0] batch_mean;
    logic [DEV_W-1:0]           batch_deviation;
    logic [KEPT_W-1:0]          kept_count;
    logic                       status;
  } batch_result_t;

  localparam int MAX_CYCLES = 3000000;

  logic                       clk;
  logic                       rst_n;
  logic                       cfg_wr_en;
  logic [CFG_W-1:0]           cfg_wr_data;
  logic                       push;
  logic                       full;
  logic signed [SAMPLE_W-1:0] in_offset_sample;
  logic                       empty;
  logic                       pop;
  logic signed [SAMPLE_W-1:0] out_correction;
  logic signed [SAMPLE_W-1:0] out_batch_mean;
  logic [DEV_W-1:0]           out_batch_deviation;
  logic [KEPT_W-1:0]          out_kept_count;
  logic                       out_status;

  logic signed [SAMPLE_W-1:0] pending_samples[$];
  batch_result_t              expected_results[$];
  logic signed [SAMPLE_W-1:0] model_store[MAX_BATCH_DEF];
  int                         model_fill;
  logic [CFG_W-1:0]           model_batch_size;
  int                         mismatches;
  bit                         idle_free;
  bit                         hold_sender;
  longint                     cycle_count;

  sigma_clipped_batch_mean_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .push               (push),
    .full               (full),
    .in_offset_sample   (in_offset_sample),
    .empty              (empty),
    .pop                (pop),
    .out_correction     (out_correction),
    .out_batch_mean     (out_batch_mean),
    .out_batch_deviation(out_batch_deviation),
    .out_kept_count     (out_kept_count),
    .out_status         (out_status)
  );

  function automatic longint div_nearest(longint a, longint d);
    longint m;
    longint q;
    m = (a < 0) ? -a : a;
    q = (m + d / 2) / d;
    return (a < 0) ? -q : q;
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(root);
  endfunction

  function automatic void store_sample(logic signed [SAMPLE_W-1:0] s);
    int n;
    longint sum;
    longint mean;
    longint dev;
    longint kept_sum;
    longint corr;
    longint d;
    longint unsigned ss;
    int kept;
    batch_result_t r;
    n = model_batch_size;
    if (n < MIN_BATCH) n = MIN_BATCH;
    if (n > MAX_BATCH_DEF) n = MAX_BATCH_DEF;
    if (model_fill >= MAX_BATCH_DEF) model_fill = 0;
    model_store[model_fill] = s;
    model_fill++;
    if (model_fill < n) return;
    model_fill = 0;
    sum = 0;
    ss = 0;
    kept_sum = 0;
    kept = 0;
    corr = 0;
    for (int i = 0; i < n; i++) sum += model_store[i];
    mean = div_nearest(sum, n);
    for (int i = 0; i < n; i++) begin
      d = model_store[i] - mean;
      ss += longint'(d * d);
    end
    dev = int_sqrt(ss / (n - 1));
    for (int i = 0; i < n; i++) begin
      if (model_store[i] > mean - dev && model_store[i] < mean + dev) begin
        kept_sum += model_store[i];
        kept++;
      end
    end
    if (kept > 0) begin
      corr = -div_nearest(kept_sum, kept);
      if (corr > 8388607) corr = 8388607;
      if (corr < -8388608) corr = -8388608;
    end
    r.correction = corr[SAMPLE_W-1:0];
    r.batch_mean = mean[SAMPLE_W-1:0];
    r.batch_deviation = (dev > 8388607) ? 23'h7FFFFF : dev[DEV_W-1:0];
    r.kept_count = (kept > 255) ? 8'd255 : kept[KEPT_W-1:0];
    r.status = (kept == 0);
    expected_results.push_back(r);
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MAX_CYCLES) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (push && !full) store_sample(in_offset_sample);
      if (!(push && !full) || pending_samples.size() == 0 || hold_sender) begin
        if (!(push && !full) && push) begin
          // The item has not been taken yet, so it is held.
        end else if (pending_samples.size() > 0 && !hold_sender &&
                     (idle_free || $urandom_range(0, 99) >= 16)) begin
          push <= 1'b1;
          in_offset_sample <= pending_samples.pop_front();
        end else begin
          push <= 1'b0;
        end
      end else if (idle_free || $urandom_range(0, 99) >= 16) begin
        push <= 1'b1;
        in_offset_sample <= pending_samples.pop_front();
      end else begin
        push <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result item");
          mismatches++;
        end else begin
          batch_result_t e;
          e = expected_results.pop_front();
          if (out_correction !== e.correction) begin
            $error("correction: expected %0d, got %0d", e.correction, out_correction);
            mismatches++;
          end
          if (out_batch_mean !== e.batch_mean) begin
            $error("batch_mean: expected %0d, got %0d", e.batch_mean, out_batch_mean);
            mismatches++;
          end
          if (out_batch_deviation !== e.batch_deviation) begin
            $error("batch_deviation: expected %0d, got %0d", e.batch_deviation,
                   out_batch_deviation);
            mismatches++;
          end
          if (out_kept_count !== e.kept_count) begin
            $error("kept_count: expected %0d, got %0d", e.kept_count, out_kept_count);
            mismatches++;
          end
          if (out_status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, out_status);
            mismatches++;
          end
        end
      end
      pop <= idle_free || $urandom_range(0, 99) >= 16;
    end
  end

  task automatic wait_drained();
    while (pending_samples.size() > 0 || push || expected_results.size() > 0)
      @(posedge clk);
    repeat (1200) @(posedge clk);
  endtask

  task automatic write_batch_size(logic [CFG_W-1:0] v);
    wait_drained();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    model_batch_size = v;
  endtask

  task automatic queue_batch(int n, int mode);
    logic signed [SAMPLE_W-1:0] base;
    int spread;
    base = SAMPLE_W'($urandom);
    spread = 1 << $urandom_range(0, 22);
    for (int i = 0; i < n; i++) begin
      case (mode)
        0: pending_samples.push_back(SAMPLE_W'($urandom));
        1: pending_samples.push_back(base + SAMPLE_W'($urandom_range(0, spread)) -
                                     SAMPLE_W'(spread / 2));
        2: pending_samples.push_back(base);
        default: pending_samples.push_back(($urandom & 1) ? 24'sh7FFFFF : -24'sh800000);
      endcase
    end
  endtask

  initial begin
    int sizes[6];
    int n;
    sizes = '{0, 4, 128, 200, 7, 33};
    rst_n = 1'b0;
    push = 1'b0;
    pop = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_offset_sample = '0;
    mismatches = 0;
    idle_free = 1'b0;
    hold_sender = 1'b0;
    cycle_count = 0;
    model_fill = 0;
    model_batch_size = BATCH_SIZE_RESET;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed batches at the reset size: extremes and constant data.
    pending_samples.push_back(24'sh7FFFFF);
    repeat (4) pending_samples.push_back(-24'sh800000);
    repeat (5) pending_samples.push_back(24'sh7FFFFF);
    repeat (10) pending_samples.push_back(24'sh000123);
    wait_drained();
    hold_sender = 1'b1;
    repeat (50) @(posedge clk);
    hold_sender = 1'b0;

    foreach (sizes[k]) begin
      write_batch_size(CFG_W'(sizes[k]));
      n = sizes[k] < 4 ? 4 : (sizes[k] > 128 ? 128 : sizes[k]);
      idle_free = (k == 2);
      for (int b = 0; b < (n > 64 ? 2 : 140 / n); b++)
        queue_batch(n, b % 9 == 8 ? 3 : (b % 7 == 6 ? 2 : b % 2));
    end
    idle_free = 1'b0;
    write_batch_size(8'd10);
    for (int b = 0; b < 10; b++) queue_batch(10, b % 2);
    // Size change within a batch.
    queue_batch(6, 0);
    wait (pending_samples.size() == 0 && !push);
    @(posedge clk);
    write_batch_size(8'd5);
    queue_batch(5, 1);
    wait_drained();

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

### files.f
+incdir+src
src/scbm_pkg.sv
src/scbm_ram.sv
src/scbm_jobq.sv
src/scbm_front.sv
src/scbm_back.sv
src/sigma_clipped_batch_mean_unit.sv
test/sigma_clipped_batch_mean_unit_tb.sv
